>>> rtl/core/sorted_ring_priority_queue_assert.svh
// Assertion macros for the sorted ring priority queue.
// Expects clk and rst in the scope of each use.
`ifndef SORTED_RING_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_RING_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRPQ_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("srpq same-cycle check failed");
`define SRPQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("srpq next-cycle check failed");
`else
`define SRPQ_ASSERT_SAME(lbl, pre, post)
`define SRPQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/srpq_pkg.sv
// Shared types and codes for the sorted ring priority queue.
// No dependencies.
package srpq_pkg;

  localparam int KEY_W   = 16;
  localparam int PAY_W   = 48;
  localparam int ENTRY_W = KEY_W + PAY_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] new_key;
    logic [PAY_W-1:0]        new_payload;
    logic [3:0]              rank;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [3:0]              occupancy;
  } res_t;

endpackage

>>> rtl/core/srpq_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on srpq_pkg.
interface srpq_cmd_if;
  import srpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [KEY_W-1:0] new_key;
  logic [PAY_W-1:0]        new_payload;
  logic [3:0]              rank;
  modport source (output valid, opcode, new_key, new_payload, rank, input ready);
  modport sink (input valid, opcode, new_key, new_payload, rank, output ready);
endinterface

interface srpq_rsp_if;
  import srpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;
  logic [3:0]              occupancy;
  modport source (output valid, status, out_key, out_payload, occupancy, input ready);
  modport sink (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

>>> rtl/core/srpq_store.sv
// Entry memory: one write port, one read port with registered read data.
// Depends on srpq_pkg for the entry width.
module srpq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [srpq_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [srpq_pkg::ENTRY_W-1:0] rdata
);
  import srpq_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/srpq_ctrl.sv
// Sequencer: ring indices, insert walk, pop and read over the entry memory.
// Depends on srpq_pkg; drives srpq_store.
module srpq_ctrl #(
  parameter int CAPACITY = 15,
  parameter int IW       = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  srpq_pkg::cmd_t                    cmd,
  input  logic signed [srpq_pkg::KEY_W-1:0] thr,
  output logic                              res_valid,
  input  logic                              res_ready,
  output srpq_pkg::res_t                    res,
  output logic                              mem_we,
  output logic [IW-1:0]                     mem_waddr,
  output logic [srpq_pkg::ENTRY_W-1:0]      mem_wdata,
  output logic [IW-1:0]                     mem_raddr,
  input  logic [srpq_pkg::ENTRY_W-1:0]      mem_rdata
);
  import srpq_pkg::*;

  localparam int SLOTS = CAPACITY + 1;
  localparam int SW    = (IW > 4 ? IW : 4) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_RDX  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] i);
    return (i == '0) ? IW'(SLOTS - 1) : i - 1'b1;
  endfunction

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    return (i == IW'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [2:0]              state;
  logic [IW-1:0]           head;
  logic [IW-1:0]           tail;
  logic [IW-1:0]           cur;
  logic [IW-1:0]           prv;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;
  logic [1:0]              res_status;
  logic [KEY_W-1:0]        res_key;
  logic [PAY_W-1:0]        res_pay;

  logic [IW:0]             cnt_sum;
  logic [IW-1:0]           cnt;
  logic [IW+3:0]           cnt_ext;
  logic [SW-1:0]           rank_sum;
  logic [SW-1:0]           rank_wrap;
  logic [IW-1:0]           rank_addr;
  logic                    rank_ok;
  logic signed [KEY_W-1:0] rd_key;
  logic                    walk_go;

  always_comb begin
    cnt_sum   = {1'b0, head} + (IW+1)'(SLOTS) - {1'b0, tail};
    cnt       = (head >= tail) ? head - tail : cnt_sum[IW-1:0];
    cnt_ext   = {4'b0, cnt};
    rank_sum  = SW'(tail) + SW'(cmd.rank);
    rank_wrap = (rank_sum >= SW'(SLOTS)) ? rank_sum - SW'(SLOTS) : rank_sum;
    rank_addr = rank_wrap[IW-1:0];
    rank_ok   = SW'(cmd.rank) < SW'(cnt);
    rd_key    = $signed(mem_rdata[ENTRY_W-1:PAY_W]);
    walk_go   = (cur != tail) && (key <= rd_key);
  end

  always_comb begin
    mem_we    = (state == S_WALK);
    mem_waddr = cur;
    mem_wdata = walk_go ? mem_rdata : {key, payload};
    case (state)
      S_IDLE: begin
        case (cmd.opcode)
          OP_INSERT: mem_raddr = dec_idx(head);
          OP_READ:   mem_raddr = rank_addr;
          default:   mem_raddr = tail;
        endcase
      end
      S_WALK:  mem_raddr = dec_idx(prv);
      default: mem_raddr = tail;
    endcase
  end

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res = '{status: res_status, out_key: res_key, out_payload: res_pay,
                 occupancy: cnt_ext[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key        <= cmd.new_key;
            payload    <= cmd.new_payload;
            res_status <= ST_DONE;
            res_key    <= '0;
            res_pay    <= '0;
            case (cmd.opcode)
              OP_INSERT: begin
                if (cnt == IW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  cur   <= head;
                  prv   <= dec_idx(head);
                  state <= S_WALK;
                end
              end
              OP_POP: begin
                if (cnt == '0) begin
                  res_status <= ST_NONE;
                  state      <= S_EMIT;
                end else begin
                  state <= S_POP;
                end
              end
              OP_READ: begin
                if (rank_ok) begin
                  state <= S_RDX;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_WALK: begin
          if (walk_go) begin
            cur <= prv;
            prv <= dec_idx(prv);
          end else begin
            head  <= inc_idx(head);
            state <= S_EMIT;
          end
        end
        S_POP: begin
          if (rd_key < thr) begin
            res_key <= mem_rdata[ENTRY_W-1:PAY_W];
            res_pay <= mem_rdata[PAY_W-1:0];
            tail    <= inc_idx(tail);
          end else begin
            res_status <= ST_NONE;
          end
          state <= S_EMIT;
        end
        S_RDX: begin
          res_key <= mem_rdata[ENTRY_W-1:PAY_W];
          res_pay <= mem_rdata[PAY_W-1:0];
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/sorted_ring_priority_queue.sv
// Sorted ring priority queue: holds up to CAPACITY keyed entries in one ring memory of
// CAPACITY+1 slots, smallest key at the tail; an insert places the new entry tailward
// of equal keys. One word in gives one word out. The insert walk moves one entry per
// cycle through the single read and write port of the memory; a full queue rejects
// the insert. The result sits in an output register, so the next command is taken
// while it waits. The threshold register resets to 1.
// Depends on srpq_pkg, srpq_if, srpq_store, srpq_ctrl and the assertion header.
`include "sorted_ring_priority_queue_assert.svh"
module sorted_ring_priority_queue #(
  parameter int CAPACITY = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  srpq_cmd_if.sink                          cmd,
  srpq_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic signed [srpq_pkg::KEY_W-1:0] cfg_data
);
  import srpq_pkg::*;

  localparam int SLOTS = CAPACITY + 1;
  localparam int IW    = $clog2(SLOTS);

  logic signed [KEY_W-1:0] thr;
  cmd_t                    cmd_word;
  res_t                    res;
  logic                    res_valid;
  logic                    res_ready;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [ENTRY_W-1:0]      mem_wdata;
  logic [IW-1:0]           mem_raddr;
  logic [ENTRY_W-1:0]      mem_rdata;
  logic                    out_valid;
  res_t                    out_word;
  logic                    full_word;
  logic                    miss_word;
  logic                    zero_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'sd1;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  assign cmd_word = '{opcode: cmd.opcode, new_key: cmd.new_key,
                      new_payload: cmd.new_payload, rank: cmd.rank};

  srpq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_word),
    .thr       (thr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  srpq_store #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_word.status;
  assign rsp.out_key     = out_word.out_key;
  assign rsp.out_payload = out_word.out_payload;
  assign rsp.occupancy   = out_word.occupancy;

  assign full_word = rsp.valid && rsp.status == ST_FULL;
  assign miss_word = rsp.valid && rsp.status != ST_DONE;
  assign zero_word = rsp.out_key == '0 && rsp.out_payload == '0;

  `SRPQ_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)
  `SRPQ_ASSERT_SAME(a_full_occupancy, full_word, rsp.occupancy == 4'(CAPACITY))
  `SRPQ_ASSERT_SAME(a_zero_on_miss, miss_word, zero_word)

endmodule

>>> test/tb_sorted_ring_priority_queue.sv
// Testbench for sorted_ring_priority_queue: directed and random command words checked
// word by word against an in-bench model of the sorted ring and its expire threshold.
// Depends on srpq_pkg, srpq_if and the queue RTL.
module tb_sorted_ring_priority_queue;
  import srpq_pkg::*;

  localparam int CAPACITY = 15;
  localparam int SLOTS = CAPACITY + 1;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS = 120;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic signed [KEY_W-1:0] cfg_data;

  srpq_cmd_if cmd ();
  srpq_rsp_if rsp ();

  sorted_ring_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  logic signed [KEY_W-1:0] ring_key [SLOTS];
  logic [PAY_W-1:0] ring_pay [SLOTS];
  int head_slot;
  int tail_slot;
  logic signed [KEY_W-1:0] threshold_q;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int errors;
  int idle_cycles;
  int send_gap;
  int send_calm;
  int stall_left;
  int recv_calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic res_t apply_queue_op(cmd_t c);
    res_t r;
    int held;
    int cur;
    int prv;
    int pos;
    r = '0;
    held = (head_slot - tail_slot + SLOTS) % SLOTS;
    case (c.opcode)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          cur = head_slot;
          prv = (head_slot + SLOTS - 1) % SLOTS;
          while (cur != tail_slot && c.new_key <= ring_key[prv]) begin
            ring_key[cur] = ring_key[prv];
            ring_pay[cur] = ring_pay[prv];
            cur = prv;
            prv = (prv + SLOTS - 1) % SLOTS;
          end
          ring_key[cur] = c.new_key;
          ring_pay[cur] = c.new_payload;
          head_slot = (head_slot + 1) % SLOTS;
        end
      end
      OP_POP: begin
        if (held != 0 && ring_key[tail_slot] < threshold_q) begin
          r.out_key = ring_key[tail_slot];
          r.out_payload = ring_pay[tail_slot];
          tail_slot = (tail_slot + 1) % SLOTS;
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_READ: begin
        if (int'(c.rank) < held) begin
          pos = (tail_slot + int'(c.rank)) % SLOTS;
          r.out_key = ring_key[pos];
          r.out_payload = ring_pay[pos];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        r.status = ST_DONE;
      end
    endcase
    r.occupancy = 4'((head_slot - tail_slot + SLOTS) % SLOTS);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PAY_W-1:0] rand_payload();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic int pick_key(int thr);
    logic signed [KEY_W-1:0] raw;
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      k = thr + int'($urandom_range(0, 8)) - 4;
      if (k < -32768) k = -32768;
      if (k > 32767) k = 32767;
      return k;
    end
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return -32768;
        1: return 32767;
        2: return -1;
        default: return 0;
      endcase
    end
    raw = 16'($urandom);
    return int'(raw);
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, int key, logic [PAY_W-1:0] pay,
                                    int rank);
    cmd_t c;
    c.opcode = op;
    c.new_key = 16'(key);
    c.new_payload = pay;
    c.rank = 4'(rank);
    return c;
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || cmd.valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= 16'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_q = 16'(value);
  endtask

  task automatic queue_directed();
    int fill_keys [10];
    fill_keys = '{5, 5, -1, 100, -32768, 32767, -200, 7, 5, 1};
    pending_cmds.push_back(make_cmd(OP_POP, 0, '0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, '0, 0));
    pending_cmds.push_back(make_cmd(OP_UNUSED, -1, '1, 15));
    pending_cmds.push_back(make_cmd(OP_INSERT, -32768, '0, 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 32767, '1, 15));
    pending_cmds.push_back(make_cmd(OP_INSERT, 5, 48'h0000_0000_00A5, 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 5, 48'h0000_0000_00B5, 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 0, rand_payload(), 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, '0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, '0, 2));
    pending_cmds.push_back(make_cmd(OP_READ, 0, '0, 4));
    pending_cmds.push_back(make_cmd(OP_READ, 0, '0, 15));
    foreach (fill_keys[i])
      pending_cmds.push_back(make_cmd(OP_INSERT, fill_keys[i], rand_payload(), 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 3, rand_payload(), 0));
    pending_cmds.push_back(make_cmd(OP_POP, 0, '0, 0));
    pending_cmds.push_back(make_cmd(OP_POP, 0, '0, 0));
  endtask

  task automatic queue_random(int thr, int count);
    int mix;
    int r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) mix = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mix)
        0: op = (r < 75) ? OP_INSERT : (r < 85) ? OP_POP : (r < 97) ? OP_READ : OP_UNUSED;
        1: op = (r < 20) ? OP_INSERT : (r < 80) ? OP_POP : (r < 97) ? OP_READ : OP_UNUSED;
        default: op = (r < 40) ? OP_INSERT : (r < 70) ? OP_POP : (r < 97) ? OP_READ : OP_UNUSED;
      endcase
      pending_cmds.push_back(make_cmd(op, pick_key(thr), rand_payload(),
                                      $urandom_range(0, 15)));
    end
  endtask

  always @(posedge clk) begin : driver
    cmd_t sent;
    cmd_t nxt;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        sent.opcode = cmd.opcode;
        sent.new_key = cmd.new_key;
        sent.new_payload = cmd.new_payload;
        sent.rank = cmd.rank;
        expected_res.push_back(apply_queue_op(sent));
      end
      if (!cmd.valid || cmd.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          cmd.valid <= 1'b1;
          cmd.opcode <= nxt.opcode;
          cmd.new_key <= nxt.new_key;
          cmd.new_payload <= nxt.new_payload;
          cmd.rank <= nxt.rank;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(20, 60);
          end else begin
            send_gap = pick_gap();
          end
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    int r;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result word: status %0d occupancy %0d", rsp.status,
                 rsp.occupancy);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.out_key !== want.out_key) begin
            $error("out_key: expected %0d, actual %0d", want.out_key, rsp.out_key);
            errors++;
          end
          if (rsp.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, actual %h", want.out_payload,
                   rsp.out_payload);
            errors++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0) recv_calm = $urandom_range(20, 80);
          else if (r < 6) stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int thresholds [8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.opcode = OP_INSERT;
    cmd.new_key = '0;
    cmd.new_payload = '0;
    cmd.rank = '0;
    rsp.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    send_gap = 0;
    send_calm = 0;
    stall_left = 0;
    recv_calm = 0;
    head_slot = 0;
    tail_slot = 0;
    threshold_q = 16'sd1;
    foreach (ring_key[i]) begin
      ring_key[i] = '0;
      ring_pay[i] = '0;
    end
    thresholds = '{32767, -32768, 0, int'($signed(16'($urandom))), -100,
                   int'($signed(16'($urandom))), 32767, int'($signed(16'($urandom)))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    foreach (thresholds[p]) begin
      wait_idle();
      write_threshold(thresholds[p]);
      queue_random(thresholds[p], PHASE_WORDS);
    end
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
